// ===== hw/rtl/sdpm_pkg.sv =====
// Package for the stereo decimating peak meter: widths, register indexes,
// reset values, shared types and the sample mask function.
// Depends on nothing; every module of the block imports it.
package sdpm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int GAIN_BITS      = 16;
    localparam int DECIM_W        = 8;
    localparam int BITS_KEPT_W    = 5;
    localparam int HOLD_W         = 16;
    localparam int THR_W          = 16;
    localparam int NUM_LEDS       = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAG_IN_W   = SAMPLE_BITS + 1;
    localparam int GAIN_MAG_W = GAIN_BITS + 1;
    localparam int PROD_W     = MAG_IN_W + GAIN_MAG_W;
    localparam int MAG_W      = PROD_W - GAIN_FRAC_BITS;

    localparam int S_TDATA_W  = 2 * SAMPLE_BITS;
    localparam int M_FIELDS_W = 2 * SAMPLE_BITS + NUM_LEDS;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [MAG_W-1:0] SAT_POS = MAG_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] SAT_NEG = MAG_W'(64'd1 << (SAMPLE_BITS - 1));

    localparam logic [CFG_IDX_W-1:0] CFG_DECIM     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_KEPT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MID   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH  = 3'd6;

    localparam logic [DECIM_W-1:0]     RST_DECIM     = 8'd1;
    localparam logic [BITS_KEPT_W-1:0] RST_BITS_KEPT = 5'd16;
    localparam logic [GAIN_BITS-1:0]   RST_GAIN      = 16'd4096;
    localparam logic [HOLD_W-1:0]      RST_HOLD      = 16'd4800;
    localparam logic [THR_W-1:0]       RST_THR_LOW   = 16'd28000;
    localparam logic [THR_W-1:0]       RST_THR_MID   = 16'd32000;
    localparam logic [THR_W-1:0]       RST_THR_HIGH  = 16'd32767;

    localparam int LED_LOW  = 0;
    localparam int LED_MID  = 1;
    localparam int LED_HIGH = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        sample_t          value;
    } lane_out_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_count;
        logic [THR_W-1:0]  thr_low;
        logic [THR_W-1:0]  thr_mid;
        logic [THR_W-1:0]  thr_high;
    } meter_cfg_t;

    function automatic logic [SAMPLE_BITS-1:0] keep_mask(input logic [BITS_KEPT_W-1:0] bk);
        int b;
        logic [SAMPLE_BITS-1:0] m;
        b = (int'(bk) > SAMPLE_BITS) ? SAMPLE_BITS : int'(bk);
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            m[i] = (i >= SAMPLE_BITS - b);
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/sdpm_lane.sv =====
// One channel lane of the peak meter: masks and scales a sample by the gain,
// then takes the magnitude and saturates it. Depends on sdpm_pkg.
module sdpm_lane (
    input  logic                            aclk,
    input  logic                            load,
    input  sdpm_pkg::sample_t               sample_in,
    input  logic [sdpm_pkg::SAMPLE_BITS-1:0] mask,
    input  logic [sdpm_pkg::GAIN_BITS-1:0]  gain,
    output sdpm_pkg::lane_out_t             result
);
    import sdpm_pkg::*;

    logic [SAMPLE_BITS-1:0] masked;
    logic [MAG_IN_W-1:0]    ext_s;
    logic [MAG_IN_W-1:0]    abs_s;
    logic [GAIN_MAG_W-1:0]  ext_g;
    logic [GAIN_MAG_W-1:0]  abs_g;
    logic                   neg_s;
    logic                   neg_g;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [MAG_W-1:0]       mag;
    logic [MAG_W-1:0]       clamped;
    logic                   neg_out;

    always_comb begin
        masked    = sample_in & mask;
        neg_s     = masked[SAMPLE_BITS-1];
        neg_g     = gain[GAIN_BITS-1];
        ext_s     = {masked[SAMPLE_BITS-1], masked};
        ext_g     = {gain[GAIN_BITS-1], gain};
        abs_s     = neg_s ? (~ext_s + 1'b1) : ext_s;
        abs_g     = neg_g ? (~ext_g + 1'b1) : ext_g;
        prod_next = PROD_W'(abs_s) * PROD_W'(abs_g);
        neg_next  = neg_s ^ neg_g;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
        end
    end

    always_comb begin
        mag     = prod_reg[PROD_W-1:GAIN_FRAC_BITS];
        neg_out = neg_reg && (mag != '0);
        if (neg_out) begin
            clamped = (mag > SAT_NEG) ? SAT_NEG : mag;
        end else begin
            clamped = (mag > SAT_POS) ? SAT_POS : mag;
        end
        result.mag   = mag;
        result.value = neg_out ? SAMPLE_BITS'(~clamped + 1'b1) : clamped[SAMPLE_BITS-1:0];
    end

endmodule

// ===== hw/rtl/sdpm_merge.sv =====
// Merging stage of the peak meter: takes the larger lane magnitude, runs the
// three hold counters and indicators, and keeps the held outputs. Depends on sdpm_pkg.
module sdpm_merge (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             update,
    input  sdpm_pkg::lane_out_t              left,
    input  sdpm_pkg::lane_out_t              right,
    input  sdpm_pkg::meter_cfg_t             cfg,
    output sdpm_pkg::sample_t                left_out,
    output sdpm_pkg::sample_t                right_out,
    output logic [sdpm_pkg::NUM_LEDS-1:0]    leds
);
    import sdpm_pkg::*;

    logic [MAG_W-1:0]    peak;
    logic [THR_W-1:0]    thr [NUM_LEDS];
    logic [NUM_LEDS-1:0] hit;
    logic [HOLD_W-1:0]   hold_reg  [NUM_LEDS];
    logic [HOLD_W-1:0]   hold_next [NUM_LEDS];
    logic [NUM_LEDS-1:0] led_reg;
    logic [NUM_LEDS-1:0] led_next;
    sample_t             left_reg;
    sample_t             right_reg;

    always_comb begin
        peak          = (left.mag > right.mag) ? left.mag : right.mag;
        thr[LED_LOW]  = cfg.thr_low;
        thr[LED_MID]  = cfg.thr_mid;
        thr[LED_HIGH] = cfg.thr_high;
        led_next      = led_reg;
        for (int i = 0; i < NUM_LEDS; i++) begin
            hit[i]       = peak > MAG_W'(thr[i]);
            hold_next[i] = hold_reg[i];
            if (hit[i]) begin
                led_next[i]  = 1'b1;
                hold_next[i] = cfg.hold_count;
            end else if (hold_reg[i] != '0) begin
                hold_next[i] = hold_reg[i] - 1'b1;
            end else begin
                led_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_reg   <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                hold_reg[i] <= '0;
            end
        end else if (update) begin
            led_reg   <= led_next;
            left_reg  <= left.value;
            right_reg <= right.value;
            for (int i = 0; i < NUM_LEDS; i++) begin
                hold_reg[i] <= hold_next[i];
            end
        end
    end

    assign left_out  = left_reg;
    assign right_out = right_reg;
    assign leds      = led_reg;

    // A running hold counter always belongs to a lit indicator.
    a_hold_implies_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((hold_reg[LED_LOW] == '0) || led_reg[LED_LOW]) &&
        ((hold_reg[LED_MID] == '0) || led_reg[LED_MID]) &&
        ((hold_reg[LED_HIGH] == '0) || led_reg[LED_HIGH]))
        else $error("hold counter running with its indicator off");

    a_leds_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !update |=> $stable(led_reg) && $stable(left_reg) && $stable(right_reg))
        else $error("meter state changed without a kept sample pair");

    a_high_hit_lights: assert property (@(posedge aclk) disable iff (!aresetn)
        update && hit[LED_HIGH] |=> led_reg[LED_HIGH] && (hold_reg[LED_HIGH] == $past(cfg.hold_count)))
        else $error("high indicator not lit after a hit");

endmodule

// ===== hw/rtl/stereo_decimating_peak_meter_unit.sv =====
// Top level of the stereo decimating peak meter: stream ports, configuration
// registers, decimation counter and pipeline control. Depends on sdpm_pkg,
// sdpm_lane and sdpm_merge.
//
//   Channel   Ports                          Contents
//   input     s_tvalid s_tready s_tdata      one stereo sample pair
//   result    m_tvalid m_tready m_tdata      held samples and three indicators
//   config    cfg_we cfg_addr cfg_wdata      register writes, no read-back
//
// One pair is taken every cycle unless the result side stalls; the multiply stage
// masks and multiplies both channels; the output stage saturates, compares with the
// thresholds and, for kept pairs, updates the hold counters and held samples.
// Reset is synchronous and active low and restores every register default.
// A stalled result holds the output register; the multiply stage still takes
// one more pair while it is empty.
module stereo_decimating_peak_meter_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // left_in [15:0], right_in [31:16]
    input  logic [sdpm_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // left_out [15:0], right_out [31:16], peak_low_on [32], peak_mid_on [33],
    // peak_high_on [34], zero fill above
    output logic [sdpm_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_we,
    input  logic [sdpm_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [sdpm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sdpm_pkg::*;

    logic [DECIM_W-1:0]     decim_reg;
    logic [BITS_KEPT_W-1:0] bits_kept_reg;
    logic [GAIN_BITS-1:0]   gain_reg;
    meter_cfg_t             meter_cfg_reg;

    logic [DECIM_W-1:0]     decim_idx_reg;
    logic [DECIM_W-1:0]     decim_idx_next;
    logic [DECIM_W:0]       idx_inc;
    logic                   keep;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_keep_reg;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   adv_out;
    logic                   accept;
    logic                   update;
    logic [SAMPLE_BITS-1:0] mask;
    lane_out_t              left_res;
    lane_out_t              right_res;
    sample_t                left_out;
    sample_t                right_out;
    logic [NUM_LEDS-1:0]    leds;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decim_reg              <= RST_DECIM;
            bits_kept_reg          <= RST_BITS_KEPT;
            gain_reg               <= RST_GAIN;
            meter_cfg_reg.hold_count <= RST_HOLD;
            meter_cfg_reg.thr_low  <= RST_THR_LOW;
            meter_cfg_reg.thr_mid  <= RST_THR_MID;
            meter_cfg_reg.thr_high <= RST_THR_HIGH;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DECIM:     decim_reg              <= cfg_wdata[DECIM_W-1:0];
                CFG_BITS_KEPT: bits_kept_reg          <= cfg_wdata[BITS_KEPT_W-1:0];
                CFG_GAIN:      gain_reg               <= cfg_wdata[GAIN_BITS-1:0];
                CFG_HOLD:      meter_cfg_reg.hold_count <= cfg_wdata[HOLD_W-1:0];
                CFG_THR_LOW:   meter_cfg_reg.thr_low  <= cfg_wdata[THR_W-1:0];
                CFG_THR_MID:   meter_cfg_reg.thr_mid  <= cfg_wdata[THR_W-1:0];
                CFG_THR_HIGH:  meter_cfg_reg.thr_high <= cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        adv_out        = !m_valid_reg || m_tready;
        s_tready       = !s1_valid_reg || adv_out;
        accept         = s_tvalid && s_tready;
        update         = s1_valid_reg && s1_keep_reg && adv_out;
        idx_inc        = {1'b0, decim_idx_reg} + 1'b1;
        keep           = idx_inc >= {1'b0, decim_reg};
        decim_idx_next = keep ? '0 : idx_inc[DECIM_W-1:0];
        s1_valid_next  = accept ? 1'b1 : (adv_out ? 1'b0 : s1_valid_reg);
        m_valid_next   = adv_out ? s1_valid_reg : m_valid_reg;
        mask           = keep_mask(bits_kept_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decim_idx_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_keep_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (accept) begin
                decim_idx_reg <= decim_idx_next;
                s1_keep_reg   <= keep;
            end
        end
    end

    sdpm_lane u_lane_left (
        .aclk      (aclk),
        .load      (accept),
        .sample_in (s_tdata[SAMPLE_BITS-1:0]),
        .mask      (mask),
        .gain      (gain_reg),
        .result    (left_res)
    );

    sdpm_lane u_lane_right (
        .aclk      (aclk),
        .load      (accept),
        .sample_in (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .mask      (mask),
        .gain      (gain_reg),
        .result    (right_res)
    );

    sdpm_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (update),
        .left      (left_res),
        .right     (right_res),
        .cfg       (meter_cfg_reg),
        .left_out  (left_out),
        .right_out (right_out),
        .leds      (leds)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({leds, right_out, left_out});

    a_stall_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && m_valid_reg)
        else $error("input stalled while the pipeline has room");

    a_result_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s1_valid_reg))
        else $error("result appeared without a pair in the multiply stage");

    a_skipped_pair_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_keep_reg && adv_out |=> $stable(m_tdata))
        else $error("a decimated pair changed the held result");

endmodule

// ===== test/tb_stereo_decimating_peak_meter_unit.sv =====
// Self-checking testbench for stereo_decimating_peak_meter_unit: a directed table of sample
// pairs and register writes, then randomized phases with random idling on both streams.
// Depends on sdpm_pkg and the block RTL; every transfer is checked against a predictor or a table row.
module tb_stereo_decimating_peak_meter_unit;
    import sdpm_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PRESSURE_PHASE  = 3;
    localparam int PAUSE_PHASE     = 5;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 4;
    localparam int STALL_LIMIT     = 3000;

    typedef struct {
        sample_t             left;
        sample_t             right;
        logic [NUM_LEDS-1:0] leds;
    } reading_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  addr;
        logic [CFG_DATA_W-1:0] value;
        sample_t               left;
        sample_t               right;
        bit                    typed;
        reading_t              reading;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the configuration registers.
    logic [DECIM_W-1:0]     cfg_decim = RST_DECIM;
    logic [BITS_KEPT_W-1:0] cfg_bits_kept = RST_BITS_KEPT;
    logic signed [GAIN_BITS-1:0] cfg_gain = RST_GAIN;
    logic [HOLD_W-1:0]      cfg_hold = RST_HOLD;
    logic [THR_W-1:0]       cfg_thr [NUM_LEDS] = '{RST_THR_LOW, RST_THR_MID, RST_THR_HIGH};

    // Meter state as the block should hold it.
    int                  decim_count = 0;
    int                  hold_left [NUM_LEDS] = '{0, 0, 0};
    logic [NUM_LEDS-1:0] leds = '0;
    sample_t             held_l = '0;
    sample_t             held_r = '0;

    reading_t  expected_readings [$];
    plan_row_t plan [$];
    int        mismatch_count = 0;
    bit        idling_on = 1'b1;
    bit        hold_off_req = 1'b0;
    int        hold_off_left = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    stereo_decimating_peak_meter_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Masks, scales and saturates one channel; mag is the unclamped magnitude.
    function automatic void scale_lane(input sample_t raw, input logic [SAMPLE_BITS-1:0] mask,
                                       output sample_t value, output longint mag);
        sample_t masked;
        longint  s;
        longint  g;
        longint  abs_s;
        longint  abs_g;
        longint  m;
        longint  lim;
        bit      neg;
        masked = raw & mask;
        s = masked;
        g = cfg_gain;
        neg = (s < 0) != (g < 0);
        abs_s = (s < 0) ? -s : s;
        abs_g = (g < 0) ? -g : g;
        m = (abs_s * abs_g) >> GAIN_FRAC_BITS;
        mag = m;
        if (m == 0) begin
            neg = 1'b0;
        end
        lim = neg ? (longint'(1) << (SAMPLE_BITS - 1)) : (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (m > lim) begin
            m = lim;
        end
        value = neg ? sample_t'(-m) : sample_t'(m);
    endfunction

    function automatic reading_t predict_reading(input sample_t l, input sample_t r);
        reading_t               res;
        longint                 mag_l;
        longint                 mag_r;
        longint                 peak;
        logic [SAMPLE_BITS-1:0] mask;
        int                     b;
        int                     nxt;
        nxt = decim_count + 1;
        if (nxt >= int'(cfg_decim)) begin
            b = (int'(cfg_bits_kept) > SAMPLE_BITS) ? SAMPLE_BITS : int'(cfg_bits_kept);
            mask = SAMPLE_BITS'(~((longint'(1) << (SAMPLE_BITS - b)) - 1));
            decim_count = 0;
            scale_lane(l, mask, held_l, mag_l);
            scale_lane(r, mask, held_r, mag_r);
            peak = (mag_l > mag_r) ? mag_l : mag_r;
            for (int i = 0; i < NUM_LEDS; i++) begin
                if (peak > longint'(cfg_thr[i])) begin
                    leds[i] = 1'b1;
                    hold_left[i] = int'(cfg_hold);
                end else if (hold_left[i] > 0) begin
                    hold_left[i]--;
                end else begin
                    leds[i] = 1'b0;
                end
            end
        end else begin
            decim_count = nxt;
        end
        res.left = held_l;
        res.right = held_r;
        res.leds = leds;
        return res;
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            1, 2: return sample_t'($urandom_range(0, 4000)) - sample_t'(2000);
            default: return sample_t'($urandom());
        endcase
    endfunction

    task automatic add_write(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.addr = addr;
        row.value = value;
        plan.push_back(row);
    endtask

    task automatic add_pair(input sample_t l, input sample_t r, input bit typed = 1'b0,
                            input sample_t el = '0, input sample_t er = '0,
                            input logic [NUM_LEDS-1:0] eleds = '0);
        plan_row_t row;
        row = '{default: '0};
        row.left = l;
        row.right = r;
        row.typed = typed;
        row.reading.left = el;
        row.reading.right = er;
        row.reading.leds = eleds;
        plan.push_back(row);
    endtask

    // Stops offering pairs, waits for every reading, then lets the pipeline settle.
    task automatic await_readings_done();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        case (addr)
            CFG_DECIM:     cfg_decim = value[DECIM_W-1:0];
            CFG_BITS_KEPT: cfg_bits_kept = value[BITS_KEPT_W-1:0];
            CFG_GAIN:      cfg_gain = value;
            CFG_HOLD:      cfg_hold = value;
            CFG_THR_LOW:   cfg_thr[LED_LOW] = value;
            CFG_THR_MID:   cfg_thr[LED_MID] = value;
            CFG_THR_HIGH:  cfg_thr[LED_HIGH] = value;
            default: ;
        endcase
    endtask

    task automatic offer_pair(input sample_t l, input sample_t r, input bit typed,
                              input reading_t typed_reading);
        reading_t predicted;
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_reading(l, r);
        expected_readings.push_back(typed ? typed_reading : predicted);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic check_reading(input logic [M_TDATA_W-1:0] word);
        reading_t want;
        sample_t  got_l;
        sample_t  got_r;
        got_l = word[SAMPLE_BITS-1:0];
        got_r = word[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (expected_readings.size() == 0) begin
            $error("unexpected result transfer: %h", word);
            mismatch_count++;
            return;
        end
        want = expected_readings.pop_front();
        if (got_l !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, got_l);
            mismatch_count++;
        end
        if (got_r !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, got_r);
            mismatch_count++;
        end
        if (word[2*SAMPLE_BITS+LED_LOW] !== want.leds[LED_LOW]) begin
            $error("peak_low_on: expected %0b, got %0b", want.leds[LED_LOW],
                   word[2*SAMPLE_BITS+LED_LOW]);
            mismatch_count++;
        end
        if (word[2*SAMPLE_BITS+LED_MID] !== want.leds[LED_MID]) begin
            $error("peak_mid_on: expected %0b, got %0b", want.leds[LED_MID],
                   word[2*SAMPLE_BITS+LED_MID]);
            mismatch_count++;
        end
        if (word[2*SAMPLE_BITS+LED_HIGH] !== want.leds[LED_HIGH]) begin
            $error("peak_high_on: expected %0b, got %0b", want.leds[LED_HIGH],
                   word[2*SAMPLE_BITS+LED_HIGH]);
            mismatch_count++;
        end
    endtask

    // Result side: checks each transfer and drives tready with random stalls and the pressure-phase hold-off.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_reading(m_tdata);
        end
        if (hold_off_req) begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_stereo_decimating_peak_meter_unit failed");
                $finish;
            end
        end
    end

    initial begin
        reading_t              blank;
        bit                    write_open;
        logic [CFG_DATA_W-1:0] vals [7];
        blank = '{default: '0};
        write_open = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: reset defaults, saturation both ways, hold of zero,
        // zero and oversized bits kept, zero and large decimation, threshold extremes.
        add_pair(16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000, 3'b000);
        add_pair(16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000, 3'b111);
        add_pair(16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000, 3'b111);
        add_pair(16'shFFFF, 16'sh0001, 1'b1, 16'shFFFF, 16'sh0001, 3'b111);
        add_write(CFG_HOLD, 16'd0);
        add_write(CFG_GAIN, 16'h8000);
        add_pair(16'sh7FFF, 16'sh8000, 1'b1, 16'sh8000, 16'sh7FFF, 3'b111);
        add_pair(16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000, 3'b000);
        add_write(CFG_GAIN, 16'd4096);
        add_write(CFG_BITS_KEPT, 16'd0);
        add_pair(16'sh7FFF, 16'sh8000, 1'b1, 16'sh0000, 16'sh0000, 3'b000);
        add_write(CFG_BITS_KEPT, 16'd1);
        add_pair(16'shFFFF, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh0000, 3'b111);
        add_write(CFG_BITS_KEPT, 16'd31);
        add_pair(16'sh1234, -16'sh1235);
        add_pair(16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh7FFF, 3'b111);
        add_write(CFG_DECIM, 16'd0);
        add_pair(16'sd100, -16'sd100);
        add_pair(-16'sd7, 16'sd7);
        add_write(CFG_DECIM, 16'd255);
        for (int i = 0; i < 4; i++) begin
            add_pair(rand_sample(), rand_sample());
        end
        add_write(CFG_DECIM, 16'd3);
        for (int i = 0; i < 5; i++) begin
            add_pair(rand_sample(), rand_sample());
        end
        add_write(CFG_DECIM, 16'd1);
        add_write(CFG_HOLD, 16'd2);
        add_write(CFG_THR_LOW, 16'd0);
        add_write(CFG_THR_MID, 16'd0);
        add_write(CFG_THR_HIGH, 16'd0);
        add_pair(16'sh0000, 16'sh0001, 1'b1, 16'sh0000, 16'sh0001, 3'b111);
        for (int i = 0; i < 3; i++) begin
            add_pair(16'sh0000, 16'sh0000);
        end
        add_write(CFG_GAIN, 16'h8000);
        add_write(CFG_THR_LOW, 16'hFFFF);
        add_write(CFG_THR_MID, 16'hFFFF);
        add_write(CFG_THR_HIGH, 16'hFFFF);
        add_pair(16'sh8000, 16'sh8000);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                if (!write_open) begin
                    await_readings_done();
                end
                write_reg(plan[i].addr, plan[i].value);
                write_open = 1'b1;
            end else begin
                if (write_open) begin
                    cfg_we <= 1'b0;
                    write_open = 1'b0;
                end
                offer_pair(plan[i].left, plan[i].right, plan[i].typed, plan[i].reading);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            idling_on = (phase != NUM_PHASES - 1) && (phase != PRESSURE_PHASE) && (phase % 4 != 2);
            case ($urandom_range(0, 9))
                0: vals[CFG_DECIM] = 16'd0;
                1: vals[CFG_DECIM] = 16'd255;
                2, 3: vals[CFG_DECIM] = 16'd1;
                default: vals[CFG_DECIM] = 16'($urandom_range(2, 6));
            endcase
            vals[CFG_BITS_KEPT] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 31))
                                                              : 16'($urandom_range(8, 16));
            case ($urandom_range(0, 7))
                0: vals[CFG_GAIN] = 16'h8000;
                1: vals[CFG_GAIN] = 16'h7FFF;
                2: vals[CFG_GAIN] = 16'd4096;
                3: vals[CFG_GAIN] = 16'(-4096);
                4: vals[CFG_GAIN] = 16'($urandom_range(0, 255));
                default: vals[CFG_GAIN] = 16'($urandom());
            endcase
            case ($urandom_range(0, 7))
                0: vals[CFG_HOLD] = 16'hFFFF;
                1, 2: vals[CFG_HOLD] = 16'($urandom());
                default: vals[CFG_HOLD] = 16'($urandom_range(0, 8));
            endcase
            for (int t = CFG_THR_LOW; t <= CFG_THR_HIGH; t++) begin
                case ($urandom_range(0, 7))
                    0: vals[t] = 16'd0;
                    1: vals[t] = 16'hFFFF;
                    default: vals[t] = 16'($urandom_range(0, 40000));
                endcase
            end
            if (phase == 1) begin
                vals[CFG_GAIN] = 16'h7FFF;
                vals[CFG_HOLD] = 16'hFFFF;
            end
            await_readings_done();
            for (int a = CFG_DECIM; a <= CFG_THR_HIGH; a++) begin
                write_reg(CFG_IDX_W'(a), vals[a]);
            end
            cfg_we <= 1'b0;
            if (phase == PRESSURE_PHASE) begin
                hold_off_req = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) begin
                    await_readings_done();
                end
                offer_pair(rand_sample(), rand_sample(), 1'b0, blank);
            end
        end

        await_readings_done();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("tb_stereo_decimating_peak_meter_unit passed");
        end else begin
            $display("tb_stereo_decimating_peak_meter_unit failed");
        end
        $finish;
    end

endmodule
